// ----- hdl/kts_pkg.sv -----
// Shared types, token codes and character helpers for the keyword token scanner.
// No dependencies; imported by every module of the block.
package kts_pkg;

    // Width of the running byte position (wraps at this width)
    localparam int POS_BITS   = 16;
    localparam int KW_SLOTS   = 5;
    localparam int KW_COUNT   = 6;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
    localparam int CNT_BITS   = $clog2(FIFO_DEPTH + 1);

    localparam logic [15:0] LEN_MAX = 16'hFFFF;

    // Token kinds
    localparam logic [4:0] KIND_END     = 5'd0;
    localparam logic [4:0] KIND_VAR     = 5'd1;
    localparam logic [4:0] KIND_IDENT   = 5'd7;
    localparam logic [4:0] KIND_NUM     = 5'd8;
    localparam logic [4:0] KIND_PLUS    = 5'd9;
    localparam logic [4:0] KIND_MINUS   = 5'd10;
    localparam logic [4:0] KIND_STAR    = 5'd11;
    localparam logic [4:0] KIND_SLASH   = 5'd12;
    localparam logic [4:0] KIND_ASSIGN  = 5'd13;
    localparam logic [4:0] KIND_CMP     = 5'd14;
    localparam logic [4:0] KIND_NOT     = 5'd15;
    localparam logic [4:0] KIND_SEMI    = 5'd16;
    localparam logic [4:0] KIND_COLON   = 5'd17;
    localparam logic [4:0] KIND_PERIOD  = 5'd18;
    localparam logic [4:0] KIND_COMMA   = 5'd19;
    localparam logic [4:0] KIND_LPAREN  = 5'd20;
    localparam logic [4:0] KIND_RPAREN  = 5'd21;
    localparam logic [4:0] KIND_LBRACK  = 5'd22;
    localparam logic [4:0] KIND_RBRACK  = 5'd23;
    localparam logic [4:0] KIND_LBRACE  = 5'd24;
    localparam logic [4:0] KIND_RBRACE  = 5'd25;
    localparam logic [4:0] KIND_UNKNOWN = 5'd26;

    // Compare operators
    localparam logic [2:0] OP_EQ = 3'd0;
    localparam logic [2:0] OP_GE = 3'd1;
    localparam logic [2:0] OP_GT = 3'd2;
    localparam logic [2:0] OP_LE = 3'd3;
    localparam logic [2:0] OP_LT = 3'd4;
    localparam logic [2:0] OP_NE = 3'd5;

    typedef logic [7:0] char_t;

    localparam char_t CH_NUL   = 8'h00;
    localparam char_t CH_EQ    = "=";
    localparam char_t CH_GT    = ">";
    localparam char_t CH_LT    = "<";
    localparam char_t CH_BANG  = "!";
    localparam char_t CH_DOT   = ".";

    // Letter slots of a pending identifier, slot 0 is the first letter
    typedef char_t [KW_SLOTS-1:0] kw_letters_t;

    localparam kw_letters_t KW_TEXT [KW_COUNT] = '{
        {CH_NUL, CH_NUL, "r", "a", "v"},
        {CH_NUL, "c", "n", "u", "f"},
        {CH_NUL, CH_NUL, CH_NUL, "f", "i"},
        {"e", "l", "i", "h", "w"},
        {CH_NUL, CH_NUL, "r", "o", "f"},
        {CH_NUL, "t", "i", "n", "i"}
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd3, 3'd4, 3'd2, 3'd5, 3'd3, 3'd4};

    // One result beat
    typedef struct packed {
        logic [4:0]  kind;
        logic [2:0]  op;
        logic [15:0] start;
        logic [15:0] len;
        logic        last_of_run;
    } token_t;

    // Up to two tokens produced by one byte
    typedef struct packed {
        logic   v0;
        logic   v1;
        token_t t0;
        token_t t1;
    } scan_out_t;

    // Result queue status seen by the top level
    typedef struct packed {
        logic [CNT_BITS-1:0] count;
        logic                room;
    } fifo_status_t;

    function automatic logic is_alpha(char_t c);
        return c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
    endfunction

    function automatic logic is_digit(char_t c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_space(char_t c);
        return c inside {8'h20, [8'h09:8'h0D]};
    endfunction

    // Single-byte token kinds; anything else is unknown
    function automatic logic [4:0] punct_kind(char_t c);
        logic [4:0] k;
        case (c)
            "+":     k = KIND_PLUS;
            "-":     k = KIND_MINUS;
            "*":     k = KIND_STAR;
            "/":     k = KIND_SLASH;
            ";":     k = KIND_SEMI;
            ":":     k = KIND_COLON;
            CH_DOT:  k = KIND_PERIOD;
            ",":     k = KIND_COMMA;
            "(":     k = KIND_LPAREN;
            ")":     k = KIND_RPAREN;
            "[":     k = KIND_LBRACK;
            "]":     k = KIND_RBRACK;
            "{":     k = KIND_LBRACE;
            "}":     k = KIND_RBRACE;
            default: k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

    // Keyword lookup for a finished identifier
    function automatic logic [4:0] ident_kind(kw_letters_t l, logic [15:0] len);
        logic [4:0] k;
        logic       hit;
        k = KIND_IDENT;
        if (len <= 16'(KW_SLOTS))
        begin
            for (int w = 0; w < KW_COUNT; w++)
            begin
                hit = (len == 16'(KW_LEN[w]));
                for (int i = 0; i < KW_SLOTS; i++)
                begin
                    if (3'(i) < KW_LEN[w] && l[i] != KW_TEXT[w][i])
                        hit = 1'b0;
                end
                if (hit)
                    k = KIND_VAR + 5'(w);
            end
        end
        return k;
    endfunction

endpackage

// ----- hdl/kts_scan.sv -----
// Scanner state and the per-byte token decision (up to two tokens per byte).
// Depends on kts_pkg.
module kts_scan
    import kts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      take,
    input  char_t     c,
    output scan_out_t res
);

    typedef enum logic [2:0] {
        M_IDLE, M_IDENT, M_INT, M_FRAC, M_EQ, M_GT, M_LT, M_BANG
    } mode_t;

    mode_t                mode_reg, mode_next;
    logic [POS_BITS-1:0]  pos_reg, pos_next;
    logic [15:0]          pstart_reg, pstart_next;
    logic [15:0]          plen_reg, plen_next;
    kw_letters_t          kw_reg, kw_next;

    logic        f_valid;
    token_t      f_tok;
    logic        s_valid;
    token_t      s_tok;
    mode_t       s_mode;
    logic [15:0] pos16;
    logic [15:0] plen_inc;
    logic        do_scan;
    logic        a_v, b_v;
    token_t      a_tok, b_tok;

    assign pos16    = 16'(pos_reg);
    assign plen_inc = (plen_reg == LEN_MAX) ? plen_reg : plen_reg + 16'd1;

    // Pending token given when its run ends
    always_comb
    begin
        f_valid           = (mode_reg != M_IDLE);
        f_tok.kind        = KIND_UNKNOWN;
        f_tok.op          = OP_EQ;
        f_tok.start       = pstart_reg;
        f_tok.len         = 16'd1;
        f_tok.last_of_run = 1'b0;
        case (mode_reg)
            M_IDENT:
            begin
                f_tok.kind = ident_kind(kw_reg, plen_reg);
                f_tok.len  = plen_reg;
            end
            M_INT, M_FRAC:
            begin
                f_tok.kind = KIND_NUM;
                f_tok.len  = plen_reg;
            end
            M_EQ:    f_tok.kind = KIND_ASSIGN;
            M_GT:
            begin
                f_tok.kind = KIND_CMP;
                f_tok.op   = OP_GT;
            end
            M_LT:
            begin
                f_tok.kind = KIND_CMP;
                f_tok.op   = OP_LT;
            end
            M_BANG:  f_tok.kind = KIND_NOT;
            default: f_tok.kind = KIND_UNKNOWN;
        endcase
    end

    // Fresh scan of a byte with nothing pending
    always_comb
    begin
        s_mode            = M_IDLE;
        s_valid           = 1'b0;
        s_tok.kind        = punct_kind(c);
        s_tok.op          = OP_EQ;
        s_tok.start       = pos16;
        s_tok.len         = 16'd1;
        s_tok.last_of_run = 1'b0;
        if (is_alpha(c))
            s_mode = M_IDENT;
        else if (is_digit(c))
            s_mode = M_INT;
        else if (c == CH_EQ)
            s_mode = M_EQ;
        else if (c == CH_GT)
            s_mode = M_GT;
        else if (c == CH_LT)
            s_mode = M_LT;
        else if (c == CH_BANG)
            s_mode = M_BANG;
        else if (!is_space(c))
            s_valid = 1'b1;
    end

    // Mode update and token selection
    always_comb
    begin
        mode_next   = mode_reg;
        pos_next    = pos_reg + 1'b1;
        pstart_next = pstart_reg;
        plen_next   = plen_reg;
        kw_next     = kw_reg;
        do_scan     = 1'b0;
        a_v         = 1'b0;
        b_v         = 1'b0;
        a_tok       = f_tok;
        b_tok       = s_tok;

        if (c == CH_NUL)
        begin
            // end of text: flush, end token, back to reset values
            a_v               = f_valid;
            b_v               = 1'b1;
            b_tok.kind        = KIND_END;
            b_tok.op          = OP_EQ;
            b_tok.start       = pos16;
            b_tok.len         = 16'd0;
            mode_next         = M_IDLE;
            pos_next          = '0;
            pstart_next       = '0;
            plen_next         = '0;
            kw_next           = '0;
        end
        else
        begin
            case (mode_reg)
                M_IDENT:
                begin
                    if (is_alpha(c))
                    begin
                        plen_next = plen_inc;
                        if (plen_reg < 16'(KW_SLOTS))
                            kw_next[plen_reg[2:0]] = c;
                    end
                    else
                        do_scan = 1'b1;
                end
                M_INT:
                begin
                    if (is_digit(c))
                        plen_next = plen_inc;
                    else if (c == CH_DOT)
                    begin
                        plen_next = plen_inc;
                        mode_next = M_FRAC;
                    end
                    else
                        do_scan = 1'b1;
                end
                M_FRAC:
                begin
                    if (is_digit(c))
                        plen_next = plen_inc;
                    else
                        do_scan = 1'b1;
                end
                M_EQ, M_GT, M_LT, M_BANG:
                begin
                    if (c == CH_EQ)
                    begin
                        b_v        = 1'b1;
                        b_tok.kind = KIND_CMP;
                        b_tok.start = pstart_reg;
                        b_tok.len  = 16'd2;
                        case (mode_reg)
                            M_EQ:    b_tok.op = OP_EQ;
                            M_GT:    b_tok.op = OP_GE;
                            M_LT:    b_tok.op = OP_LE;
                            default: b_tok.op = OP_NE;
                        endcase
                        mode_next = M_IDLE;
                    end
                    else
                        do_scan = 1'b1;
                end
                default: do_scan = 1'b1;
            endcase

            if (do_scan)
            begin
                a_v       = f_valid;
                b_v       = s_valid;
                mode_next = s_mode;
                if (s_mode != M_IDLE)
                begin
                    pstart_next = pos16;
                    plen_next   = 16'd1;
                end
                if (s_mode == M_IDENT)
                begin
                    kw_next    = '0;
                    kw_next[0] = c;
                end
            end
        end

        // final token of this byte carries the run flag
        a_tok.last_of_run = !b_v;
        b_tok.last_of_run = 1'b1;

        res.v0 = a_v || b_v;
        res.v1 = a_v && b_v;
        res.t0 = a_v ? a_tok : b_tok;
        res.t1 = b_tok;
    end

    // Scanner state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_IDLE;
            pos_reg    <= '0;
            pstart_reg <= '0;
            plen_reg   <= '0;
            kw_reg     <= '0;
        end
        else if (take)
        begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            pstart_reg <= pstart_next;
            plen_reg   <= plen_next;
            kw_reg     <= kw_next;
        end
    end

endmodule

// ----- hdl/kts_fifo.sv -----
// Small result queue: takes up to two tokens a cycle, gives one per beat.
// Depends on kts_pkg.
module kts_fifo
    import kts_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  scan_out_t    din,
    input  logic         pop,
    output token_t       head,
    output fifo_status_t status
);

    token_t              mem_reg [FIFO_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                w0, w1;
    logic [PTR_BITS-1:0] wr_ptr_1;

    assign w0       = push && din.v0;
    assign w1       = push && din.v1;
    assign wr_ptr_1 = wr_ptr_reg + 1'b1;

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_BITS'(w0) + PTR_BITS'(w1);
        rd_ptr_next = rd_ptr_reg + PTR_BITS'(pop);
        count_next  = count_reg + CNT_BITS'(w0) + CNT_BITS'(w1) - CNT_BITS'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Token storage
    always_ff @(posedge clk)
    begin
        if (w0)
            mem_reg[wr_ptr_reg] <= din.t0;
        if (w1)
            mem_reg[wr_ptr_1] <= din.t1;
    end

    assign head         = mem_reg[rd_ptr_reg];
    assign status.count = count_reg;
    assign status.room  = (count_reg <= CNT_BITS'(FIFO_DEPTH - 2));

endmodule

// ----- hdl/keyword_token_scanner_unit.sv -----
// Top level of the keyword token scanner: input byte register, scanner, result queue.
// Depends on kts_pkg, kts_scan and kts_fifo.

// Source text enters one byte per beat on char_code (0 ends the text) and tokens
// leave one per beat as kind, compare operator, start offset and length, with
// last_of_run set on the final token caused by a byte. A byte is held in an input
// register and scanned from it into a four-entry result queue when the queue has
// room, and the first token of a byte is visible once written into the queue. The
// block takes one byte every cycle while each byte gives at most one token and the
// receiver keeps out_ready high; a byte that ends a pending token and starts another
// (or the end-of-text byte after a pending token) gives two tokens, and since the
// output port moves one token per beat its tokens leave on separate beats. The
// scanner advances only when the queue has room for two tokens. No clearing pass
// follows reset.
module keyword_token_scanner_unit
    import kts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_code,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [4:0]  token_kind,
    output logic [2:0]  compare_op,
    output logic [15:0] start_offset,
    output logic [15:0] token_length,
    output logic        last_of_run
);

    logic         ir_valid_reg;
    char_t        ir_char_reg;
    logic         take;
    logic         pop;
    scan_out_t    scan_res;
    token_t       head;
    fifo_status_t fifo_st;

    assign take     = ir_valid_reg && fifo_st.room;
    assign in_ready = !ir_valid_reg || take;
    assign pop      = out_valid && out_ready;

    // Input byte register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ir_valid_reg <= 1'b0;
        else if (in_valid && in_ready)
            ir_valid_reg <= 1'b1;
        else if (take)
            ir_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            ir_char_reg <= char_code;
    end

    kts_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .c     (ir_char_reg),
        .res   (scan_res)
    );

    kts_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (take),
        .din    (scan_res),
        .pop    (pop),
        .head   (head),
        .status (fifo_st)
    );

    assign out_valid    = (fifo_st.count != '0);
    assign token_kind   = head.kind;
    assign compare_op   = head.op;
    assign start_offset = head.start;
    assign token_length = head.len;
    assign last_of_run  = head.last_of_run;

`ifndef NO_ASSERTIONS
    // queue never overfills
    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_st.count <= CNT_BITS'(FIFO_DEPTH))
        else $error("result queue overfilled");

    // the scanner only advances when two free slots exist
    a_take_room: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> fifo_st.count <= CNT_BITS'(FIFO_DEPTH - 2))
        else $error("scan advanced without queue room");

    // an end token always closes its byte's run and has no length
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && token_kind == KIND_END) |-> (last_of_run && token_length == 16'd0))
        else $error("end token malformed");

    // only compare tokens carry an operator
    a_op_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && token_kind != KIND_CMP) |-> compare_op == OP_EQ)
        else $error("operator on non-compare token");
`endif

endmodule
